// ----- hdl/lbp_3x3_stream_defines.svh -----
// Assertion helpers for the LBP stream block.
// The clock and reset are fixed to the block's port names.
`ifndef LBP_3X3_STREAM_DEFINES_SVH
`define LBP_3X3_STREAM_DEFINES_SVH

// Same-cycle implication.
`define LBP_CHECK_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LBP_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/lbp_pkg.sv -----
`default_nettype none

package lbp_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int LB_ADDR_W = $clog2(MAX_WIDTH);

   localparam int PIX_W  = 8;
   localparam int COL_W  = 10;
   localparam int ROW_W  = 16;
   localparam int WCFG_W = 11;
   localparam int HCFG_W = 16;
   localparam int CSR_W  = 16;

   // Line store entry: upper byte two rows up, lower byte one row up.
   localparam int LB_DATA_W = 2 * PIX_W;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [WCFG_W-1:0] WIDTH_RESET  = WCFG_W'(640);
   localparam logic [HCFG_W-1:0] HEIGHT_RESET = HCFG_W'(480);

   typedef struct packed {
      logic                 emit;
      logic                 last;
      logic [ROW_W-1:0]     out_row;
      logic [COL_W-1:0]     out_col;
      logic [LB_ADDR_W-1:0] addr;
   } pos_info_type;

endpackage

`default_nettype wire

// ----- hdl/lbp_ram.sv -----
`default_nettype none

module lbp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/lbp_pos.sv -----
`default_nettype none

module lbp_pos (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_en,
   input  wire logic                       csr_index,
   input  wire logic [lbp_pkg::CSR_W-1:0]  csr_wdata,
   input  wire logic                       advance,
   output      lbp_pkg::pos_info_type      info
);

   import lbp_pkg::*;

   localparam logic [WCFG_W-1:0] MAX_W = WCFG_W'(MAX_WIDTH);
   localparam logic [WCFG_W-1:0] MIN_W = WCFG_W'(3);
   localparam logic [HCFG_W-1:0] MIN_H = HCFG_W'(3);

   logic [WCFG_W-1:0] width_ff;
   logic [HCFG_W-1:0] height_ff;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   logic [WCFG_W-1:0] w_eff, w_m1;
   logic [HCFG_W-1:0] h_m1;
   logic              col_end, row_end;

   always_comb begin
      if (width_ff < MIN_W) begin
         w_eff = MIN_W;
      end else if (width_ff > MAX_W) begin
         w_eff = MAX_W;
      end else begin
         w_eff = width_ff;
      end
      w_m1 = w_eff - WCFG_W'(1);
      h_m1 = (height_ff < MIN_H) ? HCFG_W'(2) : height_ff - HCFG_W'(1);

      col_end = {1'b0, col_ff} >= w_m1;
      row_end = row_ff >= h_m1;

      info.emit    = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
      info.last    = row_end && col_end;
      info.out_row = row_ff - ROW_W'(2);
      info.out_col = col_ff - COL_W'(2);
      info.addr    = col_ff[LB_ADDR_W-1:0];

      if (col_end) begin
         col_in = '0;
         row_in = row_end ? '0 : row_ff + ROW_W'(1);
      end else begin
         col_in = col_ff + COL_W'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WCFG_W-1:0];
               CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HCFG_W-1:0];
               default: ;
            endcase
         end
         if (advance) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/lbp_win.sv -----
`default_nettype none

module lbp_win (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      shift,
   input  wire logic [lbp_pkg::PIX_W-1:0] top,
   input  wire logic [lbp_pkg::PIX_W-1:0] mid,
   input  wire logic [lbp_pkg::PIX_W-1:0] bot,
   output      logic [lbp_pkg::PIX_W-1:0] code
);

   import lbp_pkg::*;

   // 0..2: column two to the left (top, mid, bot); 3..5: column one to the left
   logic [PIX_W-1:0] win_ff [6];
   logic [PIX_W-1:0] centre;

   assign centre = win_ff[4];

   always_comb begin
      code[7] = win_ff[0] > centre;
      code[6] = win_ff[3] > centre;
      code[5] = top       > centre;
      code[4] = mid       > centre;
      code[3] = bot       > centre;
      code[2] = win_ff[5] > centre;
      code[1] = win_ff[2] > centre;
      code[0] = win_ff[1] > centre;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= bot;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/lbp_3x3_stream.sv -----
`default_nettype none

// 3x3 local binary pattern over a raster stream of 8-bit pixels. One pixel is
// taken per clock, sustained while rsp_ready stays high; once its last neighbour
// is accepted, a code passes stage 1 and is then loaded into the rsp_ register.
// The rate is set by the line store, one 1024x16 RAM holding both previous rows:
// it is read when a pixel is accepted and written back with the shifted column
// when the pixel leaves stage 1, which is delayed while the output register is
// full. Neighbouring pixels never share a column, so the read and the
// write-back never collide. A full output register that is not being drained
// holds an emitting pixel in stage 1 and drops req_ready. Only pixels whose
// centre lies inside the border produce a code (rows and columns two and up);
// out_row/out_col give the centre position minus one, and last marks the final
// code of a frame. Line-store contents after reset are undefined until the
// first two rows have passed, so no clearing pass is run.
// image_width (saturated to 3..1024) and image_height (raised to 3) are taken
// from csr index 0 and 1 and should only be changed while the block is idle.
module lbp_3x3_stream (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_en,
   input  wire logic                        csr_index,
   input  wire logic [lbp_pkg::CSR_W-1:0]   csr_wdata,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [lbp_pkg::PIX_W-1:0]   req_pixel,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic [lbp_pkg::PIX_W-1:0]   rsp_lbp_code,
   output      logic [lbp_pkg::ROW_W-1:0]   rsp_out_row,
   output      logic [lbp_pkg::COL_W-1:0]   rsp_out_col,
   output      logic                        rsp_last
);

   import lbp_pkg::*;

   logic              req_fire;
   pos_info_type      pos_info;

   // stage 1: line store data is back
   logic              s1_valid_ff, s1_valid_in;
   pos_info_type      s1_info_ff;
   logic [PIX_W-1:0]  s1_pixel_ff;
   logic              s1_adv;

   logic [LB_DATA_W-1:0] lb_rd_data;
   logic [LB_DATA_W-1:0] lb_wr_data;
   logic [PIX_W-1:0]     top_pix, mid_pix;
   logic [PIX_W-1:0]     code;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_code_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic              rsp_last_ff;

   // a non-emitting pixel never waits for the output register
   assign s1_adv    = s1_valid_ff && (!s1_info_ff.emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   assign top_pix    = lb_rd_data[LB_DATA_W-1:PIX_W];
   assign mid_pix    = lb_rd_data[PIX_W-1:0];
   assign lb_wr_data = {mid_pix, s1_pixel_ff};

   lbp_pos u_pos (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .advance      (req_fire),
      .info         (pos_info)
   );

   lbp_ram #(
      .WIDTH (LB_DATA_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_info_ff.addr),
      .wr_data (lb_wr_data),
      .rd_en   (req_fire),
      .rd_addr (pos_info.addr),
      .rd_data (lb_rd_data)
   );

   lbp_win u_win (
      .clock (clock),
      .reset (reset),
      .shift (s1_adv),
      .top   (top_pix),
      .mid   (mid_pix),
      .bot   (s1_pixel_ff),
      .code  (code)
   );

   always_comb begin
      s1_valid_in = req_fire || (s1_valid_ff && !s1_adv);
      if (s1_adv && s1_info_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_info_ff  <= pos_info;
         s1_pixel_ff <= req_pixel;
      end
      if (s1_adv && s1_info_ff.emit) begin
         rsp_code_ff <= code;
         rsp_row_ff  <= s1_info_ff.out_row;
         rsp_col_ff  <= s1_info_ff.out_col;
         rsp_last_ff <= s1_info_ff.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_lbp_code = rsp_code_ff;
   assign rsp_out_row  = rsp_row_ff;
   assign rsp_out_col  = rsp_col_ff;
   assign rsp_last     = rsp_last_ff;

`include "lbp_3x3_stream_defines.svh"

   `LBP_CHECK_NOW(a_lb_no_collide, req_fire && s1_adv,
      pos_info.addr != s1_info_ff.addr,
      "line store read and write-back hit the same column")
   `LBP_CHECK_NEXT(a_lb_data_held, s1_valid_ff && !s1_adv, $stable(lb_rd_data),
      "line store data changed under a stalled pixel")
   `LBP_CHECK_NOW(a_stall_blocks_req, s1_valid_ff && !s1_adv, !req_ready,
      "pixel accepted while stage 1 is stalled")
   `LBP_CHECK_NEXT(a_rsp_loaded, s1_adv && s1_info_ff.emit, rsp_valid,
      "emitted code did not reach the output register")

endmodule

`default_nettype wire
